// ----- src/mbbs_pkg.sv -----
package mbbs_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_WIDTH_DEF  = 24;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_SQRT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } sqrt_ctl_t;

endpackage

// ----- src/mbbs_dist_lane.sv -----
module mbbs_dist_lane
    import mbbs_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic signed [COORD_WIDTH-1:0]   coord,
    input  logic signed [COORD_WIDTH-1:0]   centre,
    output logic        [2*COORD_WIDTH+1:0] sq_reg
);

    logic signed [COORD_WIDTH:0] diff;
    logic        [COORD_WIDTH:0] mag;

    assign diff = {coord[COORD_WIDTH-1], coord} - {centre[COORD_WIDTH-1], centre};
    assign mag  = diff[COORD_WIDTH] ? -diff : diff;

    // squared offset on one axis
    always_ff @(posedge aclk) begin
        sq_reg <= mag * mag;
    end

endmodule

// ----- src/mbbs_sqrt.sv -----
module mbbs_sqrt
    import mbbs_pkg::*;
#(
    parameter int IN_WIDTH = 52
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [IN_WIDTH-1:0]   value,
    output logic                  busy,
    output logic [IN_WIDTH/2-1:0] root
);

    localparam int RW = IN_WIDTH / 2;
    localparam int CW = $clog2(RW + 1);

    logic [IN_WIDTH-1:0] rem_reg, rem_next;
    logic [RW:0]         part_reg, part_next;
    logic [RW-1:0]       res_reg, res_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [RW+2:0]       cand;
    logic [RW+2:0]       trial;
    logic [RW+3:0]       diff;

    // one result bit per cycle, restoring
    always_comb begin
        rem_next  = rem_reg;
        part_next = part_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        cand      = {part_reg, rem_reg[IN_WIDTH-1 -: 2]};
        trial     = {1'b0, res_reg, 2'b01};
        diff      = {1'b0, cand} - {1'b0, trial};
        if (start) begin
            rem_next  = value;
            part_next = '0;
            res_next  = '0;
            cnt_next  = CW'(RW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = {rem_reg[IN_WIDTH-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (!diff[RW+3]) begin
                part_next = diff[RW:0];
                res_next  = {res_reg[RW-2:0], 1'b1};
            end else begin
                part_next = cand[RW:0];
                res_next  = {res_reg[RW-2:0], 1'b0};
            end
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        part_reg <= part_next;
    end

    assign busy = busy_reg | start;
    assign root = res_reg;

endmodule

// ----- src/mesh_bounds_box_and_sphere_unit.sv -----
// result path: the stored count of vertices is scanned, the read and square pipe drains,
// the square root runs, then the result is handed off to the output register
// throughput: one vertex per cycle while loading; the input is held from the last
// vertex until its result moves into the output register
// reset: synchronous active-low aresetn clears counters, box, flags and output valid;
// the vertex memory is not cleared, only entries below the count are read
module mesh_bounds_box_and_sphere_unit
    import mbbs_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // pos_x, pos_y, pos_z, zero fill
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    // centre_x/y/z, half_ext_x/y/z, sphere_radius, overflowed, zero fill
    output logic [((7*COORD_WIDTH+1+7)/8)*8-1:0] m_tdata
);

    localparam int CW  = COORD_WIDTH;
    localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int SQW = 2 * CW + 2;
    localparam int DW  = 2 * CW + 4;
    localparam int RW  = DW / 2;
    localparam int OW  = ((7*CW+1+7)/8)*8;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    state_t state_reg, state_next;

    logic [3*CW-1:0] mem [MAX_VERTICES];
    logic [3*CW-1:0] rd_reg;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic [NW-1:0]   scan_reg, scan_next;
    logic signed [CW-1:0] mn_reg [3];
    logic signed [CW-1:0] mx_reg [3];
    logic signed [CW-1:0] ctr_reg [3];
    logic [CW-2:0]   half_reg [3];
    logic            ovf_reg, ovf_next;
    logic [DW-1:0]   best_reg;
    logic [1:0]      pipe_reg;
    logic [OW-1:0]   out_reg;
    logic            ovf_out_reg;
    logic            m_valid_reg;

    logic signed [CW-1:0] p [3];
    logic accept, store_ok, fin;
    logic [SQW-1:0] sq [3];
    logic [DW-1:0]  dsum;
    logic [RW-1:0]  root;
    logic           sqrt_busy;
    sqrt_ctl_t      sq_ctl;

    assign accept   = s_tvalid && s_tready;
    assign store_ok = cnt_reg < NW'(MAX_VERTICES);
    for (genvar a = 0; a < 3; a++) begin : g_p
        assign p[a] = s_tdata[a*CW +: CW];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:  if (accept && s_tlast) state_next = ST_SCAN;
            ST_SCAN:  if (scan_reg == cnt_reg) state_next = ST_DRAIN;
            ST_DRAIN: if (pipe_reg == 2'd0) state_next = ST_SQRT;
            ST_SQRT:  if (!sq_ctl.busy) state_next = ST_OUT;
            ST_OUT:   if (sq_ctl.done) state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == ST_LOAD);
        m_tvalid     = m_valid_reg;
        sq_ctl.busy  = sqrt_busy;
        sq_ctl.start = (state_reg == ST_DRAIN) && (pipe_reg == 2'd0);
        sq_ctl.done  = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);
        fin          = sq_ctl.done;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        scan_next    = scan_reg;
        if (accept) begin
            if (store_ok) cnt_next = cnt_reg + 1'b1;
            else ovf_next = 1'b1;
            scan_next = '0;
        end else if (state_reg == ST_SCAN && scan_reg != cnt_reg) begin
            scan_next = scan_reg + 1'b1;
        end
        if (fin) begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && store_ok) begin
            mem[cnt_reg[AW-1:0]] <= s_tdata[3*CW-1:0];
        end
        rd_reg <= mem[scan_reg[AW-1:0]];
    end

    // box and centre from the running corners
    logic signed [CW:0] span [3];
    logic signed [CW-1:0] lo [3];
    logic signed [CW-1:0] hi [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            lo[a] = (store_ok && p[a] < mn_reg[a]) ? p[a] : mn_reg[a];
            hi[a] = (store_ok && p[a] > mx_reg[a]) ? p[a] : mx_reg[a];
            span[a] = {hi[a][CW-1], hi[a]} - {lo[a][CW-1], lo[a]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || fin) begin
            for (int a = 0; a < 3; a++) begin
                mn_reg[a] <= CMAX;
                mx_reg[a] <= CMIN;
            end
        end else if (accept) begin
            for (int a = 0; a < 3; a++) begin
                mn_reg[a] <= lo[a];
                mx_reg[a] <= hi[a];
                if (s_tlast) begin
                    half_reg[a] <= span[a][CW-1:1];
                    ctr_reg[a]  <= lo[a] + CW'(span[a][CW:1]);
                end
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_lane
        mbbs_dist_lane #(.COORD_WIDTH(CW)) u_lane (
            .aclk   (aclk),
            .coord  (rd_reg[a*CW +: CW]),
            .centre (ctr_reg[a]),
            .sq_reg (sq[a])
        );
    end

    assign dsum = DW'(sq[0]) + DW'(sq[1]) + DW'(sq[2]);

    // valid pipe: memory read then lane square
    logic rd_v_reg, sq_v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            scan_reg    <= '0;
            ovf_reg     <= 1'b0;
            rd_v_reg    <= 1'b0;
            sq_v_reg    <= 1'b0;
            pipe_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            scan_reg  <= scan_next;
            ovf_reg   <= ovf_next;
            rd_v_reg  <= (state_reg == ST_SCAN) && (scan_reg != cnt_reg);
            sq_v_reg  <= rd_v_reg;
            pipe_reg  <= {1'b0, rd_v_reg} + {1'b0, sq_v_reg};
            if (fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            best_reg <= '0;
        end else if (sq_v_reg && dsum > best_reg) begin
            best_reg <= dsum;
        end
    end

    mbbs_sqrt #(.IN_WIDTH(DW)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_ctl.start),
        .value   (best_reg),
        .busy    (sqrt_busy),
        .root    (root)
    );

    always_ff @(posedge aclk) begin
        if (sq_ctl.done) begin
            out_reg     <= OW'({ovf_reg, root[CW:0],
                                half_reg[2], half_reg[1], half_reg[0],
                                ctr_reg[2], ctr_reg[1], ctr_reg[0]});
            ovf_out_reg <= ovf_reg;
        end
    end

    assign m_tdata = out_reg;

`ifndef SYNTHESIS
    a_ready_only_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_LOAD))
        else $error("ready outside load");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= NW'(MAX_VERTICES))
        else $error("count beyond capacity");
    a_ovf_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ovf_out_reg == m_tdata[7*CW-2]))
        else $error("overflow flag mismatch");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
`endif

endmodule
